// File: rtl/farbfeld_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// farbfeld stream decoder assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FARBFELD_STREAM_DECODER_ASSERT_SVH
`define FARBFELD_STREAM_DECODER_ASSERT_SVH

// condition holds at every edge out of reset
`define FFD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types, constants and the channel rounding function of the decoder.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int unsigned FFD_FIFO_DEPTH = 4;
	localparam int unsigned LIMIT_W        = 25;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd16777216;

	localparam logic [4:0] HDR_LEN     = 5'd16;
	localparam logic [4:0] IDX_WIDTH   = 5'd8;
	localparam logic [4:0] IDX_HEIGHT  = 5'd12;
	localparam logic [4:0] IDX_HEIGHT2 = 5'd14;
	localparam logic [4:0] IDX_HEIGHT3 = 5'd15;

	localparam logic [2:0] LAST_BYTE_IN_PIXEL = 3'd7;

	localparam logic [7:0] MAGIC [8] = '{8'h66, 8'h61, 8'h72, 8'h62,
	                                     8'h66, 8'h65, 8'h6C, 8'h64};

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC     = 2'd1,
		ST_INVALID   = 2'd2,
		ST_TOO_LARGE = 2'd3
	} ffd_status_t;

	typedef enum logic {
		KIND_PIXEL  = 1'b0,
		KIND_STATUS = 1'b1
	} ffd_kind_t;

	typedef struct packed {
		ffd_kind_t   kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		ffd_status_t status;
		logic        last;
	} ffd_item_t;

	typedef struct packed {
		logic      push_a;
		logic      push_b;
		ffd_item_t item_a;
		ffd_item_t item_b;
	} ffd_push_t;

	// (v*255 + 32767) / 65535; the quotient stays below 2^16, so
	// x / 65535 == (x + (x >> 16) + 1) >> 16
	function automatic logic [7:0] chan8(input logic [15:0] v);
		logic [23:0] x;
		logic [23:0] y;
		x = {v, 8'h00} - {8'h00, v} + 24'd32767;
		y = x + {16'h0000, x[23:16]} + 24'd1;
		return y[23:16];
	endfunction

endpackage

// File: rtl/ffd_out_fifo.sv
// ----------------------------------------------------------------------------
// ffd_out_fifo
// Result queue: takes up to two items per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module ffd_out_fifo
	import ffd_pkg::*;
#(
	parameter int unsigned DEPTH = FFD_FIFO_DEPTH,
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ffd_push_t        push,
	output logic             room,
	output logic             head_valid,
	input  logic             head_pop,
	output ffd_item_t        head,
	output logic [CNT_W-1:0] level
);

	ffd_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] level_q;
	logic [PTR_W-1:0] wr_p1;
	logic [PTR_W-1:0] wr_p2;
	logic [PTR_W-1:0] rd_p1;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_p1      = ptr_inc(wr_q);
	assign wr_p2      = ptr_inc(wr_p1);
	assign rd_p1      = ptr_inc(rd_q);
	assign head_valid = (level_q != '0);
	assign pop        = head_valid && head_pop;
	assign head       = mem_q[rd_q];
	assign level      = level_q;
	assign room       = (level_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem_q[wr_q] <= push.item_a;
		end
		if (push.push_b) begin
			mem_q[wr_p1] <= push.item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push.push_b) begin
				wr_q <= wr_p2;
			end else if (push.push_a) begin
				wr_q <= wr_p1;
			end
			if (pop) begin
				rd_q <= rd_p1;
			end
			level_q <= level_q + CNT_W'(push.push_a) + CNT_W'(push.push_b) - CNT_W'(pop);
		end
	end

endmodule

// File: rtl/farbfeld_stream_decoder.sv
// ----------------------------------------------------------------------------
// farbfeld_stream_decoder
// Byte-wide farbfeld parser: header checks, pixel rounding, per-file status.
// ----------------------------------------------------------------------------
// channel   direction  width  contents
// s_*       in         8+1    tdata: file_byte; tlast: end_of_file
// m_*       out        40+2   tdata: red, green, blue, alpha, status; tuser: kind
// cfg_*     in         25     pixel_limit write
//
// One byte per cycle while the output queue has room; the header and pixel logic
// handles a beat combinationally and its results are registered in the output queue.
// The end-marked byte that also completes a pixel queues two results.
// s_tready drops while fewer than two queue slots are free.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module farbfeld_stream_decoder
	import ffd_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FFD_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // file_byte[7:0]
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,   // red[7:0], green[15:8], blue[23:16],
	                                      // alpha[31:24], status[33:32], zero
	output logic               m_tuser,   // kind
	output logic               m_tlast
);

	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [LIMIT_W-1:0] limit_q;
	logic [4:0]         hdr_idx_q,        hdr_idx_nxt;
	logic               magic_q,          magic_nxt;
	logic [15:0]        width_lo_q,       width_lo_nxt;
	logic               width_hi_q,       width_hi_nxt;
	logic               height_hi_q,      height_hi_nxt;
	logic [7:0]         height_mid_q,     height_mid_nxt;
	logic [23:0]        partial_q,        partial_nxt;
	logic [LIMIT_W-1:0] expected_q,       expected_nxt;
	logic [LIMIT_W-1:0] done_q,           done_nxt;
	logic [55:0]        held_q,           held_nxt;
	logic [2:0]         byte_in_pixel_q,  byte_in_pixel_nxt;
	ffd_status_t        verdict_q,        verdict_nxt;

	logic               s_beat;
	logic               pix_fire;
	logic [31:0]        area;
	ffd_status_t        file_status;
	ffd_item_t          pix_item;
	ffd_item_t          stat_item;
	ffd_push_t          push;
	ffd_item_t          head;
	logic [CNT_W-1:0]   fifo_level;
	logic               room;

	assign s_beat   = s_tvalid && s_tready;
	assign s_tready = room;

	always_comb begin
		hdr_idx_nxt       = hdr_idx_q;
		magic_nxt         = magic_q;
		width_lo_nxt      = width_lo_q;
		width_hi_nxt      = width_hi_q;
		height_hi_nxt     = height_hi_q;
		height_mid_nxt    = height_mid_q;
		partial_nxt       = partial_q;
		expected_nxt      = expected_q;
		done_nxt          = done_q;
		held_nxt          = held_q;
		byte_in_pixel_nxt = byte_in_pixel_q;
		verdict_nxt       = verdict_q;
		pix_fire          = 1'b0;
		area              = {partial_q, 8'h00} + 32'(width_lo_q * s_tdata);
		file_status       = ST_OK;

		if (hdr_idx_q < HDR_LEN) begin
			if (hdr_idx_q < IDX_WIDTH) begin
				if (s_tdata != MAGIC[hdr_idx_q[2:0]]) begin
					magic_nxt = 1'b0;
				end
			end else if (hdr_idx_q < IDX_HEIGHT) begin
				if (hdr_idx_q == IDX_WIDTH) begin
					width_lo_nxt = {8'h00, s_tdata};
				end else begin
					width_lo_nxt = {width_lo_q[7:0], s_tdata};
					width_hi_nxt = width_hi_q || (width_lo_q[15:8] != 8'h00);
				end
			end else if (hdr_idx_q < IDX_HEIGHT2) begin
				height_hi_nxt = height_hi_q || (s_tdata != 8'h00);
			end else if (hdr_idx_q < IDX_HEIGHT3) begin
				height_mid_nxt = s_tdata;
				partial_nxt    = 24'(width_lo_q * s_tdata);
			end else begin
				if (!magic_q || (!width_hi_q && width_lo_q == 16'h0000) ||
				    (!height_hi_q && height_mid_q == 8'h00 && s_tdata == 8'h00)) begin
					verdict_nxt = ST_INVALID;
				end else if (width_hi_q || height_hi_q ||
				             area > {7'd0, limit_q}) begin
					verdict_nxt = ST_TOO_LARGE;
				end else begin
					verdict_nxt = ST_OK;
				end
				expected_nxt = (verdict_nxt == ST_OK) ? area[LIMIT_W-1:0] : '0;
			end
			hdr_idx_nxt = hdr_idx_q + 5'd1;
		end else if (verdict_q == ST_OK && done_q < expected_q) begin
			if (byte_in_pixel_q != LAST_BYTE_IN_PIXEL) begin
				held_nxt          = {held_q[47:0], s_tdata};
				byte_in_pixel_nxt = byte_in_pixel_q + 3'd1;
			end else begin
				pix_fire          = 1'b1;
				done_nxt          = done_q + LIMIT_W'(1);
				byte_in_pixel_nxt = '0;
			end
		end

		if (hdr_idx_nxt < HDR_LEN) begin
			file_status = ST_TRUNC;
		end else if (verdict_nxt != ST_OK) begin
			file_status = verdict_nxt;
		end else if (done_nxt < expected_nxt) begin
			file_status = ST_TRUNC;
		end else begin
			file_status = ST_OK;
		end

		if (s_tlast) begin
			hdr_idx_nxt       = '0;
			magic_nxt         = 1'b1;
			width_hi_nxt      = 1'b0;
			height_hi_nxt     = 1'b0;
			expected_nxt      = '0;
			done_nxt          = '0;
			byte_in_pixel_nxt = '0;
			verdict_nxt       = ST_OK;
		end
	end

	always_comb begin
		pix_item.kind   = KIND_PIXEL;
		pix_item.red    = chan8(held_q[55:40]);
		pix_item.green  = chan8(held_q[39:24]);
		pix_item.blue   = chan8(held_q[23:8]);
		pix_item.alpha  = chan8({held_q[7:0], s_tdata});
		pix_item.status = ST_OK;
		pix_item.last   = 1'b0;

		stat_item.kind   = KIND_STATUS;
		stat_item.red    = '0;
		stat_item.green  = '0;
		stat_item.blue   = '0;
		stat_item.alpha  = '0;
		stat_item.status = file_status;
		stat_item.last   = 1'b1;

		if (pix_fire) begin
			push.push_a = s_beat;
			push.push_b = s_beat && s_tlast;
			push.item_a = pix_item;
			push.item_b = stat_item;
		end else begin
			push.push_a = s_beat && s_tlast;
			push.push_b = 1'b0;
			push.item_a = stat_item;
			push.item_b = stat_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q         <= LIMIT_RESET;
			hdr_idx_q       <= '0;
			magic_q         <= 1'b1;
			width_hi_q      <= 1'b0;
			height_hi_q     <= 1'b0;
			expected_q      <= '0;
			done_q          <= '0;
			byte_in_pixel_q <= '0;
			verdict_q       <= ST_OK;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (s_beat) begin
				hdr_idx_q       <= hdr_idx_nxt;
				magic_q         <= magic_nxt;
				width_hi_q      <= width_hi_nxt;
				height_hi_q     <= height_hi_nxt;
				expected_q      <= expected_nxt;
				done_q          <= done_nxt;
				byte_in_pixel_q <= byte_in_pixel_nxt;
				verdict_q       <= verdict_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			width_lo_q   <= width_lo_nxt;
			height_mid_q <= height_mid_nxt;
			partial_q    <= partial_nxt;
			held_q       <= held_nxt;
		end
	end

	ffd_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (m_tvalid),
		.head_pop   (m_tready),
		.head       (head),
		.level      (fifo_level)
	);

	assign m_tdata = {6'b000000, head.status, head.alpha, head.blue, head.green, head.red};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

`include "farbfeld_stream_decoder_assert.svh"

	`FFD_ASSERT_ALWAYS(a_fifo_bound, fifo_level <= CNT_W'(FIFO_DEPTH), "output queue overflow")
	`FFD_ASSERT_ALWAYS(a_done_bound, done_q <= expected_q, "more pixels than expected")
	`FFD_ASSERT_IMPLY(a_hdr_no_pixel, hdr_idx_q < HDR_LEN, byte_in_pixel_q == '0 && done_q == '0, "pixel bytes counted in header")
	`FFD_ASSERT_NEXT(a_eof_clear, s_beat && s_tlast, hdr_idx_q == '0 && verdict_q == ST_OK, "file state not cleared after end beat")

endmodule

// File: tb/farbfeld_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// farbfeld_stream_decoder_tb
// Self-checking bench for the farbfeld decoder. A table of directed files
// covers short headers, bad magic, zero and oversized sides, an area at the
// limit, channel rounding and trailing bytes. Random files follow under
// several pixel_limit settings. A behavioral decoder predicts every pixel and
// status beat not set by the table, with bursty input and stalled output.
// ----------------------------------------------------------------------------
module farbfeld_stream_decoder_tb;
	import ffd_pkg::*;

	localparam int unsigned           RUN_LIMIT   = 400000;
	localparam int unsigned           TOTAL_BYTES = 800;
	localparam int                    HDR_BYTES   = 16;
	localparam logic [31:0]           SIDE_MAX    = 32'd65535;
	localparam logic [LIMIT_W-1:0]    LIMIT_TOP   = 25'd16777216;
	localparam logic [63:0]           FF_SIG      = "farbfeld";
	localparam int                    PREDICTED   = -1;
	localparam int                    PAT_RANDOM  = 0;
	localparam int                    PAT_ZERO    = 1;
	localparam int                    PAT_ONES    = 2;
	localparam int                    PAT_ROUND   = 3;

	localparam logic [15:0] ROUND_CASES [8] = '{16'h0080, 16'h0081, 16'h7FFF, 16'h8000,
	                                           16'h0101, 16'hFF7F, 16'hFF80, 16'h017F};

	typedef struct {
		int          hdr_len;
		bit          bad_magic;
		logic [31:0] w;
		logic [31:0] h;
		int          n_pix;
		int          extra;
		int          pat;
		int          st;
	} file_row_t;

	file_row_t dir_rows [18] = '{
		'{16, 0, 1,          1,          1, 0,  PAT_ZERO,   ST_OK},
		'{16, 0, 1,          1,          1, 0,  PAT_ONES,   ST_OK},
		'{16, 0, 2,          1,          2, 0,  PAT_ROUND,  PREDICTED},
		'{16, 0, 1,          2,          2, 11, PAT_RANDOM, ST_OK},
		'{1,  0, 1,          1,          0, 0,  PAT_RANDOM, ST_TRUNC},
		'{15, 0, 1,          1,          0, 0,  PAT_RANDOM, ST_TRUNC},
		'{16, 0, 1,          1,          0, 0,  PAT_RANDOM, ST_TRUNC},
		'{16, 0, 2,          2,          3, 4,  PAT_RANDOM, ST_TRUNC},
		'{16, 1, 1,          1,          1, 0,  PAT_RANDOM, ST_INVALID},
		'{16, 0, 0,          5,          1, 0,  PAT_RANDOM, ST_INVALID},
		'{16, 0, 5,          0,          1, 0,  PAT_RANDOM, ST_INVALID},
		'{16, 1, 65536,      1,          0, 0,  PAT_RANDOM, ST_INVALID},
		'{16, 0, 65536,      1,          1, 0,  PAT_RANDOM, ST_TOO_LARGE},
		'{16, 0, 1,          65536,      0, 3,  PAT_RANDOM, ST_TOO_LARGE},
		'{16, 0, 65535,      65535,      0, 0,  PAT_RANDOM, ST_TOO_LARGE},
		'{16, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, PAT_RANDOM, ST_TOO_LARGE},
		'{16, 0, 4096,       4096,       1, 0,  PAT_ROUND,  ST_TRUNC},
		'{16, 0, 65535,      1,          2, 0,  PAT_RANDOM, ST_TRUNC}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // file_byte[7:0]
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;   // red[7:0], green[15:8], blue[23:16],
	                               // alpha[31:24], status[33:32], zero
	logic               m_tuser;   // kind
	logic               m_tlast;

	// decoder state mirrored by the bench
	int                 hdr_seen;
	bit                 sig_ok;
	logic [31:0]        img_w;
	logic [31:0]        img_h;
	int unsigned        px_total;
	int unsigned        px_done;
	logic [55:0]        px_hold;
	int                 px_fill;
	ffd_status_t        verdict;
	logic [LIMIT_W-1:0] limit_now;

	ffd_item_t          due_items [$];
	int                 typed_status = PREDICTED;
	int unsigned        mismatches   = 0;
	int unsigned        cycles       = 0;
	int unsigned        bytes_sent   = 0;
	int                 burst_left   = 0;
	int unsigned        stall_tick   = 0;
	int                 stall_mode   = 0;

	farbfeld_stream_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] round8(input logic [15:0] v);
		int unsigned t;
		t = v * 255 + 32767;
		return 8'(t / 65535);
	endfunction

	task automatic clear_file();
		hdr_seen = 0;
		sig_ok   = 1'b1;
		img_w    = '0;
		img_h    = '0;
		px_total = 0;
		px_done  = 0;
		px_hold  = '0;
		px_fill  = 0;
		verdict  = ST_OK;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eof);
		ffd_item_t   res;
		logic [63:0] px;
		logic [63:0] area;
		ffd_status_t st;
		if (hdr_seen < HDR_BYTES) begin
			if (hdr_seen < 8) begin
				if (b != FF_SIG[63 - 8 * hdr_seen -: 8])
					sig_ok = 1'b0;
			end else if (hdr_seen < 12) begin
				img_w = {img_w[23:0], b};
			end else begin
				img_h = {img_h[23:0], b};
			end
			hdr_seen++;
			if (hdr_seen == HDR_BYTES) begin
				area = 64'(img_w) * 64'(img_h);
				if (!sig_ok || img_w == 0 || img_h == 0)
					verdict = ST_INVALID;
				else if (img_w > SIDE_MAX || img_h > SIDE_MAX || area > 64'(limit_now))
					verdict = ST_TOO_LARGE;
				else
					verdict = ST_OK;
				px_total = (verdict == ST_OK) ? int'(area[31:0]) : 0;
			end
		end else if (verdict == ST_OK && px_done < px_total) begin
			if (px_fill < 7) begin
				px_hold = {px_hold[47:0], b};
				px_fill++;
			end else begin
				px        = {px_hold, b};
				res       = '0;
				res.kind  = KIND_PIXEL;
				res.red   = round8(px[63:48]);
				res.green = round8(px[47:32]);
				res.blue  = round8(px[31:16]);
				res.alpha = round8(px[15:0]);
				due_items.push_back(res);
				px_done++;
				px_fill = 0;
			end
		end
		if (eof) begin
			if (hdr_seen < HDR_BYTES)
				st = ST_TRUNC;
			else if (verdict != ST_OK)
				st = verdict;
			else if (px_done < px_total)
				st = ST_TRUNC;
			else
				st = ST_OK;
			if (typed_status != PREDICTED)
				st = ffd_status_t'(typed_status);
			res        = '0;
			res.kind   = KIND_STATUS;
			res.status = st;
			res.last   = 1'b1;
			due_items.push_back(res);
			clear_file();
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eof);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eof;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, eof);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_file(input int hdr_len, input bit bad_magic, input logic [31:0] w,
	                         input logic [31:0] h, input int n_pix, input int extra,
	                         input int pat);
		logic [7:0]  hdr [16];
		logic [7:0]  fb [$];
		logic [15:0] v;
		int          k;
		int          c;
		for (k = 0; k < 8; k++)
			hdr[k] = FF_SIG[63 - 8 * k -: 8];
		if (bad_magic) begin
			k      = $urandom_range(0, 7);
			hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(0, 7));
		end
		for (k = 0; k < 4; k++) begin
			hdr[8 + k]  = w[31 - 8 * k -: 8];
			hdr[12 + k] = h[31 - 8 * k -: 8];
		end
		for (k = 0; k < hdr_len; k++)
			fb.push_back(hdr[k]);
		for (k = 0; k < n_pix; k++) begin
			for (c = 0; c < 4; c++) begin
				case (pat)
					PAT_ZERO:  v = 16'h0000;
					PAT_ONES:  v = 16'hFFFF;
					PAT_ROUND: v = ROUND_CASES[$urandom_range(0, 7)];
					default:   v = 16'($urandom);
				endcase
				fb.push_back(v[15:8]);
				fb.push_back(v[7:0]);
			end
		end
		for (k = 0; k < extra; k++)
			fb.push_back(8'($urandom));
		for (k = 0; k < fb.size(); k++)
			send_byte(fb[k], k == fb.size() - 1);
	endtask

	task automatic random_file();
		int          pick;
		int          pat;
		logic [31:0] w;
		logic [31:0] h;
		pick = $urandom_range(0, 99);
		pat  = ($urandom_range(0, 9) < 7) ? PAT_RANDOM : $urandom_range(PAT_ZERO, PAT_ROUND);
		w    = $urandom_range(1, 3);
		h    = $urandom_range(1, 3);
		if ($urandom_range(0, 5) == 0) begin
			w = $urandom_range(1, 12);
			h = 1;
		end
		if (pick < 70) begin
			send_file(HDR_BYTES, 0, w, h, w * h,
			          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0, pat);
		end else if (pick < 80) begin
			send_file(HDR_BYTES, 0, w, h, $urandom_range(0, w * h - 1),
			          $urandom_range(0, 7), pat);
		end else if (pick < 85) begin
			send_file($urandom_range(1, HDR_BYTES - 1), 0, w, h, 0, 0, pat);
		end else if (pick < 89) begin
			send_file(HDR_BYTES, 1, w, h, w * h, 0, pat);
		end else if (pick < 94) begin
			case ($urandom_range(0, 2))
				0:       w = 0;
				1:       h = 0;
				default: begin
					w = 0;
					h = 0;
				end
			endcase
			send_file(HDR_BYTES, 0, w, h, 1, 0, pat);
		end else begin
			if ($urandom_range(0, 1) == 0)
				w = $urandom;
			else
				h = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
			send_file(HDR_BYTES, 0, w, h, 0, $urandom_range(0, 9), pat);
		end
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] val);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (due_items.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_now = val;
	endtask

	task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= (stall_tick % 4 == 3);
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin : result_mon
		ffd_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_items.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual tdata=%h tuser=%b tlast=%b",
				         $time, m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want = due_items.pop_front();
				cmp_field("kind",   want.kind,   m_tuser);
				cmp_field("red",    want.red,    m_tdata[7:0]);
				cmp_field("green",  want.green,  m_tdata[15:8]);
				cmp_field("blue",   want.blue,   m_tdata[23:16]);
				cmp_field("alpha",  want.alpha,  m_tdata[31:24]);
				cmp_field("status", want.status, m_tdata[33:32]);
				cmp_field("pad",    0,           m_tdata[39:34]);
				cmp_field("last",   want.last,   m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		int phase;
		int files;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tlast     <= 1'b0;
		clear_file();
		limit_now = LIMIT_TOP;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(dir_rows); r++) begin
			typed_status = dir_rows[r].st;
			send_file(dir_rows[r].hdr_len, dir_rows[r].bad_magic, dir_rows[r].w,
			          dir_rows[r].h, dir_rows[r].n_pix, dir_rows[r].extra, dir_rows[r].pat);
		end
		typed_status = PREDICTED;

		phase = 0;
		files = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			if (files % 5 == 0) begin
				case (phase)
					0:       set_limit(25'd1);
					1:       set_limit(LIMIT_TOP);
					default: begin
						case ($urandom_range(0, 3))
							0:       set_limit(25'd1);
							1:       set_limit(LIMIT_TOP);
							2:       set_limit(LIMIT_W'($urandom_range(2, 12)));
							default: set_limit(LIMIT_W'($urandom_range(1, LIMIT_TOP)));
						endcase
					end
				endcase
				phase++;
			end
			random_file();
			files++;
		end

		s_tvalid <= 1'b0;
		while (due_items.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
